>>> src/flpc_pkg.sv
`timescale 1ns / 1ps

package flpc_pkg;

  // Configuration register indexes, in register-map order.
  typedef enum logic [2:0] {
    REG_FIELD_MARGIN      = 3'd0,
    REG_YELLOW_NORM_RED   = 3'd1,
    REG_YELLOW_NORM_GREEN = 3'd2,
    REG_YELLOW_NORM_BLUE  = 3'd3,
    REG_YELLOW_ABS_RED    = 3'd4,
    REG_YELLOW_ABS_GREEN  = 3'd5,
    REG_YELLOW_ABS_BLUE   = 3'd6,
    REG_WHITE_THRESHOLD   = 3'd7
  } cfg_index_t;

  // Reset values of the configuration registers.
  localparam logic [7:0] RST_FIELD_MARGIN      = 8'd34;
  localparam logic [6:0] RST_YELLOW_NORM_RED   = 7'd38;
  localparam logic [6:0] RST_YELLOW_NORM_GREEN = 7'd38;
  localparam logic [6:0] RST_YELLOW_NORM_BLUE  = 7'd20;
  localparam logic [7:0] RST_YELLOW_ABS_RED    = 8'd230;
  localparam logic [7:0] RST_YELLOW_ABS_GREEN  = 8'd230;
  localparam logic [7:0] RST_YELLOW_ABS_BLUE   = 8'd160;
  localparam logic [7:0] RST_WHITE_THRESHOLD   = 8'd200;

  // Green pixels allowed in the background region before it ends.
  localparam logic [7:0] GREEN_RUN_LIMIT = 8'd5;
  localparam logic [7:0] GREEN_COUNT_MAX = 8'd255;

  // Scale of the normalized chroma thresholds (hundredths).
  localparam logic [14:0] NORM_SCALE = 15'd100;

  typedef struct packed {
    logic [7:0] field_margin;
    logic [6:0] yellow_norm_red;
    logic [6:0] yellow_norm_green;
    logic [6:0] yellow_norm_blue;
    logic [7:0] yellow_abs_red;
    logic [7:0] yellow_abs_green;
    logic [7:0] yellow_abs_blue;
    logic [7:0] white_threshold;
  } cfg_regs_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Per-pixel test results, independent of column state.
  typedef struct packed {
    logic yellow;
    logic green;
    logic white;
  } pix_class_t;

endpackage

>>> src/flpc_cfg.sv
`timescale 1ns / 1ps

module flpc_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output flpc_pkg::cfg_regs_t regs
);
  import flpc_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  // Writes are always taken; the register map decodes the index.
  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        REG_FIELD_MARGIN:      regs_nxt.field_margin      = cfg_data;
        REG_YELLOW_NORM_RED:   regs_nxt.yellow_norm_red   = cfg_data[6:0];
        REG_YELLOW_NORM_GREEN: regs_nxt.yellow_norm_green = cfg_data[6:0];
        REG_YELLOW_NORM_BLUE:  regs_nxt.yellow_norm_blue  = cfg_data[6:0];
        REG_YELLOW_ABS_RED:    regs_nxt.yellow_abs_red    = cfg_data;
        REG_YELLOW_ABS_GREEN:  regs_nxt.yellow_abs_green  = cfg_data;
        REG_YELLOW_ABS_BLUE:   regs_nxt.yellow_abs_blue   = cfg_data;
        REG_WHITE_THRESHOLD:   regs_nxt.white_threshold   = cfg_data;
        default:               regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.field_margin      <= RST_FIELD_MARGIN;
      regs_r.yellow_norm_red   <= RST_YELLOW_NORM_RED;
      regs_r.yellow_norm_green <= RST_YELLOW_NORM_GREEN;
      regs_r.yellow_norm_blue  <= RST_YELLOW_NORM_BLUE;
      regs_r.yellow_abs_red    <= RST_YELLOW_ABS_RED;
      regs_r.yellow_abs_green  <= RST_YELLOW_ABS_GREEN;
      regs_r.yellow_abs_blue   <= RST_YELLOW_ABS_BLUE;
      regs_r.white_threshold   <= RST_WHITE_THRESHOLD;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

>>> src/flpc_classify.sv
`timescale 1ns / 1ps

module flpc_classify (
  input  flpc_pkg::pixel_t     pix,
  input  flpc_pkg::cfg_regs_t  regs,
  output flpc_pkg::pix_class_t cls
);
  import flpc_pkg::*;

  logic [9:0]  sum;
  logic [14:0] red_scaled;
  logic [14:0] green_scaled;
  logic [14:0] blue_scaled;
  logic [16:0] red_limit;
  logic [16:0] green_limit;
  logic [16:0] blue_limit;
  logic        norm_yellow;
  logic        abs_yellow;
  logic        yellow;
  logic [10:0] green_lhs;
  logic [10:0] green_rhs;

  // Channel sum for the normalized shares.
  assign sum = {2'b00, pix.red} + {2'b00, pix.green} + {2'b00, pix.blue};

  // Normalized test as cross products: 100*C compared with thr*(R+G+B).
  // A black pixel has a zero sum, so none of these can pass.
  assign red_scaled   = {7'd0, pix.red} * NORM_SCALE;
  assign green_scaled = {7'd0, pix.green} * NORM_SCALE;
  assign blue_scaled  = {7'd0, pix.blue} * NORM_SCALE;
  assign red_limit    = {10'd0, regs.yellow_norm_red} * {7'd0, sum};
  assign green_limit  = {10'd0, regs.yellow_norm_green} * {7'd0, sum};
  assign blue_limit   = {10'd0, regs.yellow_norm_blue} * {7'd0, sum};

  assign norm_yellow = ({2'b00, red_scaled} > red_limit) &&
                       ({2'b00, green_scaled} > green_limit) &&
                       ({2'b00, blue_scaled} < blue_limit);

  // Absolute test on raw channel values.
  assign abs_yellow = (pix.red > regs.yellow_abs_red) &&
                      (pix.green > regs.yellow_abs_green) &&
                      (pix.blue < regs.yellow_abs_blue);

  assign yellow = norm_yellow || abs_yellow;

  // Field green: 2G exceeds R + B + 2*threshold, and yellow wins over green.
  assign green_lhs = {2'b00, pix.green, 1'b0};
  assign green_rhs = {3'b000, pix.red} + {3'b000, pix.blue} +
                     {2'b00, regs.field_margin, 1'b0};

  assign cls.yellow = yellow;
  assign cls.green  = (green_lhs > green_rhs) && !yellow;
  assign cls.white  = (pix.red > regs.white_threshold) &&
                      (pix.green > regs.white_threshold) &&
                      (pix.blue > regs.white_threshold);

endmodule

>>> src/field_line_pixel_classifier_top.sv
`timescale 1ns / 1ps

// Pixel classifier for a column-ordered RGB stream. Each accepted pixel
// gives exactly one result, in order: goal-yellow flag, field-green flag
// (inside the background region only), background-region flag and a
// line-candidate flag (white, outside the background region only). A
// column_start pixel restarts the background region and its green count.
// The block takes one pixel per clock unless the output stalls: a pixel
// is captured in an input register, classified by short logic (three
// 7x10 multiplies and compares) and held in a result register, and a
// stalled output holds one result plus one captured pixel. The
// configuration port accepts a write in every cycle.
module field_line_pixel_classifier_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  input  logic        in_tuser,   // [0] column_start
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] line_pixel, [1] yellow_pixel,
                                  // [2] field_green, [3] in_background, rest 0
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import flpc_pkg::*;

  cfg_regs_t  regs;
  pix_class_t cls;

  logic       in_fire;
  logic       out_load;
  logic       s1_fire;

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  pixel_t     s1_pix_r;
  logic       s1_start_r;

  logic       out_tvalid_r;
  logic       out_tvalid_nxt;
  logic [3:0] out_flags_r;
  logic [3:0] out_flags_nxt;

  logic [7:0] green_count_r;
  logic [7:0] green_count_nxt;
  logic       background_r;
  logic       background_nxt;

  logic       bg_eff;
  logic [7:0] count_eff;
  logic [7:0] count_inc;

  flpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  flpc_classify u_classify (
    .pix  (s1_pix_r),
    .regs (regs),
    .cls  (cls)
  );

  // Pipeline handshake: the result register loads when empty or drained.
  assign out_load  = !out_tvalid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_load;
  assign in_tready = !s1_valid_r || out_load;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_valid_nxt   = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_tvalid_nxt = out_load ? s1_valid_r : out_tvalid_r;

  // Column state as seen by this pixel; a column start resets it first.
  assign bg_eff    = s1_start_r || background_r;
  assign count_eff = s1_start_r ? 8'd0 : green_count_r;
  assign count_inc = (count_eff == GREEN_COUNT_MAX) ? count_eff : count_eff + 8'd1;

  always_comb begin
    green_count_nxt = count_eff;
    background_nxt  = bg_eff;
    if (bg_eff && cls.green) begin
      green_count_nxt = count_inc;
      background_nxt  = (count_inc <= GREEN_RUN_LIMIT);
    end
  end

  // Result flags, bit order as on out_tdata.
  assign out_flags_nxt = {bg_eff, bg_eff && cls.green, cls.yellow,
                          !bg_eff && cls.white};

  // Control and column state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_tvalid_r  <= 1'b0;
      green_count_r <= 8'd0;
      background_r  <= 1'b1;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (s1_fire) begin
        green_count_r <= green_count_nxt;
        background_r  <= background_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r   <= pixel_t'(in_tdata);
      s1_start_r <= in_tuser;
    end
    if (s1_fire) begin
      out_flags_r <= out_flags_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0000, out_flags_r};

`ifndef SYNTHESIS
  // A stalled result with a pixel waiting behind it blocks new input.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_tvalid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while both stages are full and stalled");

  // The output holds no result right after reset.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A line candidate is never reported inside the background region.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[3]))
    else $error("line pixel reported inside background region");

  // Field green only inside the background region and never on yellow.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2]) |-> (out_tdata[3] && !out_tdata[1]))
    else $error("field green outside background or on a yellow pixel");

  // A column start always opens a background region.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_start_r) |=> out_tdata[3])
    else $error("column start did not open a background region");
`endif

endmodule

>>> bench/pixel_class_checker.sv
`timescale 1ns / 1ps

// Watches the pixel, result and register channels of the classifier. Each
// accepted pixel is classified here from its own copy of the registers and
// column state, and each accepted result is checked against the oldest
// prediction still waiting.
module pixel_class_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  input  logic        in_tuser,   // [0] column_start
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [0] line_pixel, [1] yellow_pixel,
                                  // [2] field_green, [3] in_background
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          classes_pending,
  output int          classes_checked
);
  import flpc_pkg::*;

  // One predicted result, laid out like the low nibble of out_tdata.
  typedef struct packed {
    logic in_bg;
    logic field;
    logic yellow;
    logic line;
  } pix_verdict_t;

  cfg_regs_t    regs;
  logic [7:0]   green_run;
  logic         bg_region;
  pix_verdict_t expected_verdicts[$];

  // Classify one pixel and advance the column state.
  function automatic pix_verdict_t classify_pixel(input logic [7:0] r, g, b,
                                                  input logic col_start);
    int unsigned  rv, gv, bv, sum;
    logic         yel_norm, yel_abs, yel, grn;
    pix_verdict_t v;
    v  = '0;
    rv = r;
    gv = g;
    bv = b;
    sum = rv + gv + bv;
    if (col_start) begin
      green_run = '0;
      bg_region = 1'b1;
    end
    // Chroma shares are compared in hundredths by cross-multiplying, so a
    // black pixel fails every normalized test.
    yel_norm = (NORM_SCALE * rv > regs.yellow_norm_red * sum) &&
               (NORM_SCALE * gv > regs.yellow_norm_green * sum) &&
               (NORM_SCALE * bv < regs.yellow_norm_blue * sum);
    yel_abs  = (r > regs.yellow_abs_red) && (g > regs.yellow_abs_green) &&
               (b < regs.yellow_abs_blue);
    yel = yel_norm || yel_abs;
    grn = (2 * gv > rv + bv + 2 * regs.field_margin) && !yel;
    v.yellow = yel;
    v.in_bg  = bg_region;
    if (bg_region) begin
      v.field = grn;
      if (grn) begin
        if (green_run != GREEN_COUNT_MAX)
          green_run = green_run + 8'd1;
        bg_region = (green_run <= GREEN_RUN_LIMIT);
      end
    end else begin
      v.line = (r > regs.white_threshold) && (g > regs.white_threshold) &&
               (b > regs.white_threshold);
    end
    return v;
  endfunction

  task automatic check_field(input string what, input logic [3:0] want,
                             input logic [3:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: result %0d %s expected %0h got %0h",
               $time, classes_checked, what, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    pix_verdict_t want;
    if (!rst_n) begin
      regs.field_margin      = RST_FIELD_MARGIN;
      regs.yellow_norm_red   = RST_YELLOW_NORM_RED;
      regs.yellow_norm_green = RST_YELLOW_NORM_GREEN;
      regs.yellow_norm_blue  = RST_YELLOW_NORM_BLUE;
      regs.yellow_abs_red    = RST_YELLOW_ABS_RED;
      regs.yellow_abs_green  = RST_YELLOW_ABS_GREEN;
      regs.yellow_abs_blue   = RST_YELLOW_ABS_BLUE;
      regs.white_threshold   = RST_WHITE_THRESHOLD;
      green_run       = '0;
      bg_region       = 1'b1;
      mismatches      = 0;
      classes_pending = 0;
      classes_checked = 0;
      expected_verdicts.delete();
    end else begin
      // Result transfer: compare with the oldest prediction.
      if (out_tvalid && out_tready) begin
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          $display("%0t ns: result %0h arrived with no pixel waiting",
                   $time, out_tdata);
        end else begin
          want = expected_verdicts.pop_front();
          classes_pending--;
          check_field("line_pixel", {3'd0, want.line}, {3'd0, out_tdata[0]});
          check_field("yellow_pixel", {3'd0, want.yellow}, {3'd0, out_tdata[1]});
          check_field("field_green", {3'd0, want.field}, {3'd0, out_tdata[2]});
          check_field("in_background", {3'd0, want.in_bg}, {3'd0, out_tdata[3]});
          check_field("unused bits", 4'd0, out_tdata[7:4]);
          classes_checked++;
        end
      end
      // Pixel transfer: predict its result and queue it at the tail.
      if (in_tvalid && in_tready) begin
        expected_verdicts.insert(expected_verdicts.size(),
                                 classify_pixel(in_tdata[7:0], in_tdata[15:8],
                                                in_tdata[23:16], in_tuser));
        classes_pending++;
      end
      // Register transfer: narrow registers keep only their low bits.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          REG_FIELD_MARGIN:      regs.field_margin      = cfg_data;
          REG_YELLOW_NORM_RED:   regs.yellow_norm_red   = cfg_data[6:0];
          REG_YELLOW_NORM_GREEN: regs.yellow_norm_green = cfg_data[6:0];
          REG_YELLOW_NORM_BLUE:  regs.yellow_norm_blue  = cfg_data[6:0];
          REG_YELLOW_ABS_RED:    regs.yellow_abs_red    = cfg_data;
          REG_YELLOW_ABS_GREEN:  regs.yellow_abs_green  = cfg_data;
          REG_YELLOW_ABS_BLUE:   regs.yellow_abs_blue   = cfg_data;
          REG_WHITE_THRESHOLD:   regs.white_threshold   = cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

// Drives column-ordered pixels and register settings into the classifier
// with bursty input and a stalling output, and reports the verdict.
module tb;
  import flpc_pkg::*;

  localparam int RESET_CYCLES = 9;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_SLACK  = 4;    // margin after the last result returns

  typedef enum int {SHADE_GRASS, SHADE_WHITE, SHADE_GOLD, SHADE_DARK,
                    SHADE_ANY} shade_t;
  typedef enum int {SINK_OPEN, SINK_CHOPPY, SINK_CLOGGED} sink_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  int   mismatches;
  int   classes_pending;
  int   classes_checked;
  int   pixels_sent   = 0;
  int   columns_begun = 0;
  int   settings_run  = 0;
  int   burst_left    = 0;
  int   idle_cycles   = 0;
  logic long_hold     = 1'b0;

  field_line_pixel_classifier_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pixel_class_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .classes_pending (classes_pending),
    .classes_checked (classes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Send one pixel, opening a new burst after a random gap when needed.
  task automatic push_pixel(input logic [7:0] r, g, b, input logic col_start);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    in_tuser  <= col_start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
    if (col_start) columns_begun++;
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (classes_pending != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Write all registers; byte i of vals goes to register index i.
  task automatic program_regs(input logic [63:0] vals);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[8*i +: 8];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  function automatic logic [23:0] pick_pixel(input shade_t shade);
    logic [7:0] r, g, b;
    case (shade)
      SHADE_GRASS: begin
        r = 8'($urandom_range(0, 90));
        g = 8'($urandom_range(120, 255));
        b = 8'($urandom_range(0, 90));
      end
      SHADE_WHITE: begin
        r = 8'($urandom_range(180, 255));
        g = 8'($urandom_range(180, 255));
        b = 8'($urandom_range(180, 255));
      end
      SHADE_GOLD: begin
        r = 8'($urandom_range(150, 255));
        g = 8'($urandom_range(150, 255));
        b = 8'($urandom_range(0, 60));
      end
      SHADE_DARK: begin
        r = 8'($urandom_range(0, 8));
        g = 8'($urandom_range(0, 8));
        b = 8'($urandom_range(0, 8));
      end
      default: begin
        r = 8'($urandom_range(0, 255));
        g = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
      end
    endcase
    return {b, g, r};
  endfunction

  function automatic logic [63:0] random_regs();
    logic [63:0] v;
    v = '0;
    v[8*REG_FIELD_MARGIN +: 8]      = 8'($urandom_range(0, 80));
    v[8*REG_YELLOW_NORM_RED +: 8]   = {($urandom_range(0, 3) == 0),
                                       7'($urandom_range(10, 70))};
    v[8*REG_YELLOW_NORM_GREEN +: 8] = {($urandom_range(0, 3) == 0),
                                       7'($urandom_range(10, 70))};
    v[8*REG_YELLOW_NORM_BLUE +: 8]  = {($urandom_range(0, 3) == 0),
                                       7'($urandom_range(5, 110))};
    v[8*REG_YELLOW_ABS_RED +: 8]    = 8'($urandom_range(120, 255));
    v[8*REG_YELLOW_ABS_GREEN +: 8]  = 8'($urandom_range(120, 255));
    v[8*REG_YELLOW_ABS_BLUE +: 8]   = 8'($urandom_range(20, 255));
    v[8*REG_WHITE_THRESHOLD +: 8]   = 8'($urandom_range(100, 255));
    return v;
  endfunction

  // Columns of random height, mostly flagged at the top, with grass as
  // the commonest shade, so the background region ends and line pixels
  // follow. A few start flags are dropped or land mid-column.
  task automatic run_columns(input int n_pixels);
    int          goal, col_len, k, roll;
    shade_t      shade;
    logic [23:0] px;
    logic        col_start;
    goal = pixels_sent + n_pixels;
    while (pixels_sent < goal) begin
      col_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                            : $urandom_range(1, 30);
      for (k = 0; k < col_len && pixels_sent < goal; k++) begin
        col_start = (k == 0);
        if ($urandom_range(0, 29) == 0) col_start = !col_start;
        roll = $urandom_range(0, 99);
        if (roll < 40)      shade = SHADE_GRASS;
        else if (roll < 55) shade = SHADE_WHITE;
        else if (roll < 65) shade = SHADE_GOLD;
        else if (roll < 70) shade = SHADE_DARK;
        else                shade = SHADE_ANY;
        px = pick_pixel(shade);
        push_pixel(px[7:0], px[15:8], px[23:16], col_start);
      end
    end
  endtask

  // Output side: segments of open, choppy and mostly closed ready, plus
  // one long hold-off on request so the block backs up into its input.
  initial begin : result_sink
    int         seg_len;
    sink_mode_t mode;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      mode    = sink_mode_t'($urandom_range(0, 2));
      seg_len = $urandom_range(1, 40);
      repeat (seg_len) begin
        @(posedge clk);
        if (long_hold) begin
          out_tready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
          long_hold = 1'b0;
        end
        case (mode)
          SINK_OPEN:   out_tready <= 1'b1;
          SINK_CHOPPY: out_tready <= ($urandom_range(0, 1) == 1);
          default:     out_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Give up when no transfer happens on any channel for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, classes_pending);
      $display("field_line_pixel_classifier_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pixels under the reset settings. The first ones come before
    // any column start and belong to the column begun at reset.
    push_pixel(8'd0, 8'd0, 8'd0, 1'b0);         // black
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);   // white inside background
    push_pixel(8'd255, 8'd255, 8'd159, 1'b0);   // yellow by absolute test only
    push_pixel(8'd160, 8'd240, 8'd0, 1'b0);     // green shape, but yellow wins
    // Six green pixels end the background region.
    push_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    repeat (5) push_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);   // line pixel
    push_pixel(8'd201, 8'd201, 8'd200, 1'b0);   // blue just at threshold
    push_pixel(8'd0, 8'd255, 8'd0, 1'b0);       // green after background
    push_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b1);   // new column, back in background
    push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    push_pixel(8'd240, 8'd240, 8'd10, 1'b0);    // yellow by both tests
    push_pixel(8'd0, 8'd34, 8'd0, 1'b0);        // green excess exactly at threshold
    push_pixel(8'd0, 8'd35, 8'd0, 1'b0);        // one above
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);

    run_columns(200);
    drain_results();
    long_hold = 1'b1;
    run_columns(200);
    drain_results();

    // All registers at zero, then all bits set (narrow registers clip).
    program_regs(64'h0);
    run_columns(250);
    drain_results();
    program_regs(64'hFFFF_FFFF_FFFF_FFFF);
    run_columns(250);
    drain_results();

    // Zero share thresholds, blue share limit above 100, widest abs window.
    program_regs(64'h00FF_0000_7F00_0000);
    run_columns(300);
    drain_results();

    for (int p = 0; p < 3; p++) begin
      program_regs(random_regs());
      run_columns(250);
      drain_results();
    end

    $display("Sent %0d pixels with %0d flagged column starts under %0d register settings.",
             pixels_sent, columns_begun, settings_run + 1);
    $display("Checked %0d results, %0d mismatches.", classes_checked, mismatches);
    if (mismatches == 0) begin
      $display("field_line_pixel_classifier_top verification clean");
    end else begin
      $display("field_line_pixel_classifier_top verification failed");
    end
    $finish;
  end

endmodule

>>> field_line_pixel_classifier_top.f
src/flpc_pkg.sv
src/flpc_cfg.sv
src/flpc_classify.sv
src/field_line_pixel_classifier_top.sv
bench/pixel_class_checker.sv
bench/tb.sv
